[rtl/kurt_pkg.sv]
// Package for the keyed user rule table: request/response structs, codes, constants.
// No dependencies.
`default_nettype none
package kurt_pkg;
    localparam int KEY_LIMIT = 24;

    typedef enum logic [2:0] {
        FUNC_ENSURE = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_SET    = 3'd2,
        FUNC_READ   = 3'd3,
        FUNC_INDEX  = 3'd4
    } func_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  key_len;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [7:0]  output_number;
        logic [7:0]  rule_in;
        logic [7:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  rule_out;
        logic [4:0]  key_len_out;
        logic [63:0] key_out0;
        logic [63:0] key_out1;
        logic [63:0] key_out2;
        logic [4:0]  entries_used;
    } rsp_t;

    // Keep the bytes of one key word that lie below the key length.
    function automatic logic [63:0] mask_word(input logic [4:0] len, input int word,
                                              input logic [63:0] d);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (32'(len) > word * 8 + b) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return d & m;
    endfunction
endpackage
`default_nettype wire

[rtl/kurt_cmp.sv]
// Shared key comparator: one stored entry against the request key per cycle.
// Depends on kurt_pkg.
`default_nettype none
module kurt_cmp (
    input  wire logic [4:0]   a_len,
    input  wire logic [191:0] a_key,
    input  wire logic [4:0]   b_len,
    input  wire logic [191:0] b_key,
    output logic              hit
);
    import kurt_pkg::*;
    assign hit = (a_len == b_len) && (a_key == b_key);
endmodule
`default_nettype wire

[rtl/keyed_user_rule_table.sv]
// Keyed user rule table. One request at a time under a small sequencer.
// Next request taken the cycle after the result is accepted. Per request, search examines
// the stored users one at a time, then decide and done states follow; insert also clears the
// new user's rule row, set writes the rule, read passes rule and read-wait states,
// remove shifts each later entry down (read then write each rule word); the rule row move
// dominates a remove. Reset clears the user count and other registers, not the memories.
`default_nettype none
module keyed_user_rule_table #(
    parameter int USER_SLOTS   = 16,
    parameter int OUTPUT_SLOTS = 16,
    parameter int RULE_BITS    = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire kurt_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output kurt_pkg::rsp_t      out_data
);
    import kurt_pkg::*;

    localparam int UW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int CW = $clog2(USER_SLOTS + 1);
    localparam int OW = (OUTPUT_SLOTS > 1) ? $clog2(OUTPUT_SLOTS) : 1;
    localparam int RD = USER_SLOTS * OUTPUT_SLOTS;
    localparam int RW = (RD > 1) ? $clog2(RD) : 1;
    localparam int RB = (RULE_BITS < 8) ? RULE_BITS : 8;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_DECIDE = 8'b0000_0100,
        ST_CLEAR  = 8'b0000_1000,
        ST_SHIFT  = 8'b0001_0000,
        ST_RULE   = 8'b0010_0000,
        ST_RDWAIT = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [191:0] key_reg, key_next;
    logic [CW-1:0] total_reg, total_next;
    logic [UW:0]   idx_reg, idx_next;     // search / shift pointer, can hold USER_SLOTS
    logic          found_reg, found_next;
    logic [UW-1:0] hit_reg, hit_next;
    logic [OW:0]   col_reg, col_next;
    logic          shift_ph_reg, shift_ph_next;
    rsp_t          rsp_reg, rsp_next;
    logic          out_valid_reg, out_valid_next;

    logic [191:0]         key_mem [USER_SLOTS];
    logic [4:0]           len_mem [USER_SLOTS];
    logic [RULE_BITS-1:0] rule_mem [RD];
    logic [RULE_BITS-1:0] rule_rd_reg;

    logic                 key_we;
    logic [UW-1:0]        key_wa;
    logic [191:0]         key_wd;
    logic [4:0]           len_wd;
    logic                 rule_we;
    logic [RW-1:0]        rule_wa;
    logic [RULE_BITS-1:0] rule_wd;

    logic       len_ok, outn_ok, hit;
    logic [191:0] cur_key;
    logic [4:0]   cur_len;
    logic [UW-1:0] idx_lo;

    assign idx_lo  = idx_reg[UW-1:0];
    assign cur_key = key_mem[idx_lo];
    assign cur_len = len_mem[idx_lo];
    assign len_ok  = (req_reg.key_len != 5'd0) && (32'(req_reg.key_len) < KEY_LIMIT);
    assign outn_ok = (req_reg.output_number != 8'd0) &&
                     (32'(req_reg.output_number) <= OUTPUT_SLOTS);

    kurt_cmp u_cmp (
        .a_len (cur_len),
        .a_key (cur_key),
        .b_len (req_reg.key_len),
        .b_key (key_reg),
        .hit   (hit)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    logic [RW-1:0] rule_addr;
    logic [RW-1:0] row_base;
    assign row_base = RW'(32'(hit_reg) * OUTPUT_SLOTS);

    always_comb
    begin
        rule_addr = row_base + RW'(col_reg[OW-1:0]);
        if (state_reg == ST_SHIFT) begin
            rule_addr = RW'(32'(idx_lo) * OUTPUT_SLOTS) + RW'(col_reg[OW-1:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        col_next       = col_reg;
        shift_ph_next  = shift_ph_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg;
        key_we         = 1'b0;
        key_wa         = idx_lo - 1'b1;
        key_wd         = cur_key;
        len_wd         = cur_len;
        rule_we        = 1'b0;
        rule_wa        = rule_addr;
        rule_wd        = '0;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    req_next   = in_data;
                    key_next   = {mask_word(in_data.key_len, 2, in_data.key_word2),
                                  mask_word(in_data.key_len, 1, in_data.key_word1),
                                  mask_word(in_data.key_len, 0, in_data.key_word0)};
                    idx_next   = '0;
                    found_next = 1'b0;
                    col_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // step the compare unit over the stored users
                if (!len_ok || found_reg || 32'(idx_reg) >= 32'(total_reg)) begin
                    state_next = ST_DECIDE;
                end else if (hit) begin
                    found_next = 1'b1;
                    hit_next   = idx_lo;
                    state_next = ST_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                rsp_next = '0;
                rsp_next.entries_used = 5'(total_reg);
                state_next = ST_DONE;
                case (req_reg.func) inside
                    FUNC_ENSURE, FUNC_SET: begin
                        if (req_reg.func == FUNC_SET && !outn_ok) begin
                            state_next = ST_DONE;
                        end else if (found_reg) begin
                            col_next = (OW+1)'(req_reg.output_number - 8'd1);
                            state_next = (req_reg.func == FUNC_SET) ? ST_RULE : ST_DONE;
                            rsp_next.ok = (req_reg.func == FUNC_ENSURE);
                        end else if (len_ok && 32'(total_reg) < USER_SLOTS) begin
                            hit_next   = UW'(total_reg);
                            key_we     = 1'b1;
                            key_wa     = UW'(total_reg);
                            key_wd     = key_reg;
                            len_wd     = req_reg.key_len;
                            total_next = total_reg + 1'b1;
                            col_next   = '0;
                            found_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (found_reg) begin
                            idx_next = (UW+1)'(hit_reg) + 1'b1;
                            col_next = '0;
                            shift_ph_next = 1'b0;
                            state_next = ST_SHIFT;
                        end
                    end
                    FUNC_READ: begin
                        if (found_reg && outn_ok) begin
                            col_next = (OW+1)'(req_reg.output_number - 8'd1);
                            state_next = ST_RULE;
                        end
                    end
                    FUNC_INDEX: begin
                        if (32'(req_reg.slot_index) < 32'(total_reg)) begin
                            rsp_next.ok = 1'b1;
                            rsp_next.key_len_out = len_mem[UW'(req_reg.slot_index)];
                            {rsp_next.key_out2, rsp_next.key_out1, rsp_next.key_out0}
                                = key_mem[UW'(req_reg.slot_index)];
                        end
                    end
                    default: ;
                endcase
            end
            ST_CLEAR: begin
                // zero the new user's rule row one word per cycle
                rule_we = 1'b1;
                rule_wa = row_base + RW'(col_reg[OW-1:0]);
                if (32'(col_reg) == OUTPUT_SLOTS - 1) begin
                    rsp_next.entries_used = 5'(total_reg);
                    if (req_reg.func == FUNC_SET) begin
                        col_next   = (OW+1)'(req_reg.output_number - 8'd1);
                        state_next = ST_RULE;
                    end else begin
                        rsp_next.ok = 1'b1;
                        state_next  = ST_DONE;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_SHIFT: begin
                // move entry idx down to idx-1; each rule word is read, then written
                if (32'(idx_reg) >= 32'(total_reg)) begin
                    total_next = total_reg - 1'b1;
                    rsp_next.ok = 1'b1;
                    rsp_next.entries_used = 5'(total_reg - 1'b1);
                    state_next = ST_DONE;
                end else if (!shift_ph_reg) begin
                    shift_ph_next = 1'b1;
                    if (col_reg == '0) begin
                        key_we = 1'b1;
                    end
                end else begin
                    shift_ph_next = 1'b0;
                    rule_we = 1'b1;
                    rule_wa = RW'(32'(idx_lo - 1'b1) * OUTPUT_SLOTS) + RW'(col_reg[OW-1:0]);
                    rule_wd = rule_rd_reg;
                    if (32'(col_reg) == OUTPUT_SLOTS - 1) begin
                        col_next = '0;
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_RULE: begin
                if (req_reg.func == FUNC_SET) begin
                    rule_we = 1'b1;
                    rule_wd = RULE_BITS'(req_reg.rule_in[RB-1:0]);
                    rsp_next.ok = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_RDWAIT;
                end
            end
            ST_RDWAIT: begin
                rsp_next.ok = 1'b1;
                rsp_next.rule_out = 8'(rule_rd_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            key_reg       <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            col_reg       <= '0;
            shift_ph_reg  <= 1'b0;
            rsp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            key_reg       <= key_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            hit_reg       <= hit_next;
            col_reg       <= col_next;
            shift_ph_reg  <= shift_ph_next;
            rsp_reg       <= rsp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
            len_mem[key_wa] <= len_wd;
        end
        if (rule_we) begin
            rule_mem[rule_wa] <= rule_wd;
        end
        rule_rd_reg <= rule_mem[rule_addr];
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= USER_SLOTS) else $error("user count beyond capacity");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready) else $error("ready while result pending");
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (total_reg == $past(total_reg)))
        else $error("user count moved while idle");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid_reg) else $error("result lost");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
endmodule
`default_nettype wire
